>>> rtl/ppe_pkg.sv
// ----------------------------------------------------------------------------
// ppe_pkg
// Shared types, codes and colour tables for the 2bpp palette pixel expander.
// ----------------------------------------------------------------------------
package ppe_pkg;

  // Widths of the item fields.
  localparam int unsigned FuncW  = 3;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned RgbW   = 24;
  localparam int unsigned Lanes  = 4;

  // Packed stream widths, padded to whole bytes.
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 112;

  // Function codes carried in the input tuser.
  typedef enum logic [FuncW-1:0] {
    FUNC_RENDER     = 3'd0,
    FUNC_PAL_WRITE  = 3'd1,
    FUNC_PAL_READ   = 3'd2,
    FUNC_HOST_BEGIN = 3'd3,
    FUNC_SET_DARK   = 3'd4,
    FUNC_DISP_RESET = 3'd5
  } func_t;

  // Display modes. Code 3 is never produced and is treated as normal.
  typedef enum logic [1:0] {
    MODE_PALE   = 2'd0,
    MODE_DARK   = 2'd1,
    MODE_NORMAL = 2'd2
  } mode_t;

  typedef logic [RgbW-1:0] rgb_t;
  typedef rgb_t [Lanes-1:0] colour_tbl_t;

  // Per-item status from the control block to the output stage.
  typedef struct packed {
    logic [ByteW-1:0] read_data;
    logic             host_started;
    logic             pale_blue;
  } ppe_status_t;

  // Fixed colours.
  localparam rgb_t ColCyan      = 24'h00FFFF;
  localparam rgb_t ColDark0     = 24'h0000FF;
  localparam rgb_t ColDark1     = 24'h49658F;
  localparam rgb_t ColDark2     = 24'h7891B5;
  localparam rgb_t ColNormal0   = 24'hD8D8D8;
  localparam rgb_t ColNormal1   = 24'hD00000;
  localparam rgb_t ColNormal2   = 24'h00A000;
  localparam rgb_t ColNormal3   = 24'h000000;

  // Scale a 3-bit channel to 8 bits: c * 255 / 7, truncated.
  function automatic logic [7:0] expand3(input logic [2:0] c);
    logic [7:0] v;
    case (c)
      3'd0:    v = 8'd0;
      3'd1:    v = 8'd36;
      3'd2:    v = 8'd72;
      3'd3:    v = 8'd109;
      3'd4:    v = 8'd145;
      3'd5:    v = 8'd182;
      3'd6:    v = 8'd218;
      default: v = 8'd255;
    endcase
    return v;
  endfunction

  // Scale a 2-bit channel to 8 bits: c * 255 / 3.
  function automatic logic [7:0] expand2(input logic [1:0] c);
    logic [7:0] v;
    case (c)
      2'd0:    v = 8'd0;
      2'd1:    v = 8'd85;
      2'd2:    v = 8'd170;
      default: v = 8'd255;
    endcase
    return v;
  endfunction

  // Palette entries hold inverted RGB332; return the RGB888 colour.
  function automatic rgb_t expand_entry(input logic [ByteW-1:0] value);
    logic [ByteW-1:0] v;
    v = ~value;
    return {expand3(v[7:5]), expand3(v[4:2]), expand2(v[1:0])};
  endfunction

endpackage

>>> rtl/palette_pixel_expander_2bpp_unit.sv
// ----------------------------------------------------------------------------
// palette_pixel_expander_2bpp_unit
// Expands 2bpp video bytes into four RGB888 pixels through a palette.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one command item per transfer; in_tuser selects
//   the function (render, palette write, palette read, begin host mode, set
//   dark blue, display reset) and in_tdata carries the byte, palette index
//   and write value. Every accepted item gives exactly one result item on the
//   output stream with four pixels, read data and two flags.
//   Four pixel lanes look up the colours of one byte in parallel and the
//   output stage merges them into the result.
//   A result is registered: it is written into the output buffer at the clock
//   edge that accepts its item. Throughput is one item per cycle while
//   in_tready is high, as the palette and mode registers update on every item.
//   The output side has a two-entry buffer, so in_tready stays high while one
//   result waits; it is low while both entries are full, which only a stall
//   of the receiver brings about, and rises the cycle after the receiver
//   takes a result.
//   Reset clears both buffer entries, zeroes the palette, leaves host mode
//   and puts the display in pale-blue mode.
// ----------------------------------------------------------------------------
module palette_pixel_expander_2bpp_unit #(
  parameter int unsigned PALETTE_DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [7:0] pixel_byte, [11:8] palette_index, [19:12] write_value, rest zero
  input  logic [ppe_pkg::InDataW-1:0]      in_tdata,
  // [2:0] func
  input  logic [ppe_pkg::FuncW-1:0]        in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [23:0] pixel_first, [47:24] pixel_second, [71:48] pixel_third,
  // [95:72] pixel_fourth, [103:96] read_data, [104] host_mode_started,
  // [105] is_pale_blue, rest zero
  output logic [ppe_pkg::OutDataW-1:0]     out_tdata
);

  logic                 item_fire;
  logic                 render_en;
  ppe_pkg::colour_tbl_t colours;
  ppe_pkg::colour_tbl_t pixels;
  ppe_pkg::ppe_status_t status;

  assign item_fire = in_tvalid && in_tready;

  // Palette, mode state and colour table.
  ppe_ctrl #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_fire     (item_fire),
    .func          (in_tuser),
    .palette_index (in_tdata[11:8]),
    .write_value   (in_tdata[19:12]),
    .colours       (colours),
    .render_en     (render_en),
    .status        (status)
  );

  // One lane per pixel; lane 0 is the first pixel, from bits 7:6.
  for (genvar g = 0; g < ppe_pkg::Lanes; g++) begin : g_lane
    ppe_lane u_lane (
      .colours   (colours),
      .render_en (render_en),
      .sel       (in_tdata[7 - 2*g -: 2]),
      .pixel     (pixels[g])
    );
  end

  // Merge and output buffer.
  ppe_out_buf u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (item_fire),
    .push_ready (in_tready),
    .pixels     (pixels),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> rtl/ppe_ctrl.sv
// ----------------------------------------------------------------------------
// ppe_ctrl
// Palette registers, mode state and the four-colour table for the lanes.
// ----------------------------------------------------------------------------
module ppe_ctrl #(
  parameter int unsigned PALETTE_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       item_fire,
  input  logic [ppe_pkg::FuncW-1:0]  func,
  input  logic [ppe_pkg::IdxW-1:0]   palette_index,
  input  logic [ppe_pkg::ByteW-1:0]  write_value,
  output ppe_pkg::colour_tbl_t       colours,
  output logic                       render_en,
  output ppe_pkg::ppe_status_t       status
);

  localparam int unsigned AddrW = $clog2(PALETTE_DEPTH);

  logic [ppe_pkg::ByteW-1:0] palette_r   [PALETTE_DEPTH];
  logic [ppe_pkg::ByteW-1:0] palette_nxt [PALETTE_DEPTH];
  ppe_pkg::mode_t            mode_r, mode_nxt;
  logic                      host_r, host_nxt;
  logic                      prog_r, prog_nxt;
  logic                      idx_ok;
  logic [AddrW-1:0]          addr;

  assign idx_ok = {1'b0, palette_index} < (ppe_pkg::IdxW + 1)'(PALETTE_DEPTH);
  assign addr   = palette_index[AddrW-1:0];

  // Next state for the accepted item.
  always_comb begin
    palette_nxt = palette_r;
    mode_nxt    = mode_r;
    host_nxt    = host_r;
    prog_nxt    = prog_r;
    if (item_fire) begin
      case (func)
        ppe_pkg::FUNC_PAL_WRITE: begin
          if (idx_ok) begin
            palette_nxt[addr] = write_value;
          end
          if (host_r) begin
            prog_nxt = 1'b1;
            mode_nxt = ppe_pkg::MODE_NORMAL;
          end
        end
        ppe_pkg::FUNC_HOST_BEGIN: begin
          if (!host_r) begin
            host_nxt = 1'b1;
            prog_nxt = 1'b0;
            mode_nxt = ppe_pkg::MODE_NORMAL;
          end
        end
        ppe_pkg::FUNC_SET_DARK: begin
          mode_nxt = ppe_pkg::MODE_DARK;
        end
        ppe_pkg::FUNC_DISP_RESET: begin
          for (int i = 0; i < PALETTE_DEPTH; i++) begin
            palette_nxt[i] = '0;
          end
          mode_nxt = ppe_pkg::MODE_PALE;
          host_nxt = 1'b0;
          prog_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PALETTE_DEPTH; i++) begin
        palette_r[i] <= '0;
      end
      mode_r <= ppe_pkg::MODE_PALE;
      host_r <= 1'b0;
      prog_r <= 1'b0;
    end else begin
      palette_r <= palette_nxt;
      mode_r    <= mode_nxt;
      host_r    <= host_nxt;
      prog_r    <= prog_nxt;
    end
  end

  // Colour table seen by a render item, taken from the state before it.
  always_comb begin
    case (mode_r)
      ppe_pkg::MODE_PALE: begin
        colours = {ppe_pkg::ColCyan, ppe_pkg::ColCyan, ppe_pkg::ColCyan, ppe_pkg::ColCyan};
      end
      ppe_pkg::MODE_DARK: begin
        colours = {ppe_pkg::ColCyan, ppe_pkg::ColDark2, ppe_pkg::ColDark1, ppe_pkg::ColDark0};
      end
      default: begin
        if (prog_r) begin
          colours = {ppe_pkg::expand_entry(palette_r[AddrW'(3)]),
                     ppe_pkg::expand_entry(palette_r[AddrW'(2)]),
                     ppe_pkg::expand_entry(palette_r[AddrW'(1)]),
                     ppe_pkg::expand_entry(palette_r[AddrW'(0)])};
        end else begin
          colours = {ppe_pkg::ColNormal3, ppe_pkg::ColNormal2,
                     ppe_pkg::ColNormal1, ppe_pkg::ColNormal0};
        end
      end
    endcase
  end

  assign render_en = (func == ppe_pkg::FUNC_RENDER);

  // Status fields of the result.
  always_comb begin
    status.read_data    = '0;
    if ((func == ppe_pkg::FUNC_PAL_READ) && idx_ok) begin
      status.read_data = palette_r[addr];
    end
    status.host_started = (func == ppe_pkg::FUNC_HOST_BEGIN) && !host_r;
    status.pale_blue    = (mode_nxt == ppe_pkg::MODE_PALE);
  end

endmodule

>>> rtl/ppe_lane.sv
// ----------------------------------------------------------------------------
// ppe_lane
// One pixel lane: picks the colour for a 2-bit index from the colour table.
// ----------------------------------------------------------------------------
module ppe_lane (
  input  ppe_pkg::colour_tbl_t colours,
  input  logic                 render_en,
  input  logic [1:0]           sel,
  output ppe_pkg::rgb_t        pixel
);

  // Non-render items give a black (zero) pixel.
  assign pixel = render_en ? colours[sel] : '0;

endmodule

>>> rtl/ppe_out_buf.sv
// ----------------------------------------------------------------------------
// ppe_out_buf
// Merges the lane pixels and status into one result item and holds it in a
// two-entry output buffer (main register plus skid register).
// ----------------------------------------------------------------------------
module ppe_out_buf (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            push_ready,
  input  ppe_pkg::colour_tbl_t            pixels,
  input  ppe_pkg::ppe_status_t            status,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ppe_pkg::OutDataW-1:0]    out_tdata
);

  localparam int unsigned UsedW = ppe_pkg::Lanes * ppe_pkg::RgbW + ppe_pkg::ByteW + 2;

  logic [ppe_pkg::OutDataW-1:0] word;
  logic [ppe_pkg::OutDataW-1:0] main_r, main_nxt;
  logic [ppe_pkg::OutDataW-1:0] skid_r, skid_nxt;
  logic                         main_v_r, main_v_nxt;
  logic                         skid_v_r, skid_v_nxt;
  logic                         pop;

  // Pack the result: pixels first to fourth, read data, host flag, pale flag.
  assign word = {(ppe_pkg::OutDataW - UsedW)'(0), status.pale_blue, status.host_started,
                 status.read_data, pixels[3], pixels[2], pixels[1], pixels[0]};

  assign pop        = main_v_r && out_tready;
  assign push_ready = !skid_v_r;

  // Buffer control.
  always_comb begin
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    if (pop) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end else if (push) begin
        main_nxt = word;
      end else begin
        main_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_v_r) begin
        main_nxt   = word;
        main_v_nxt = 1'b1;
      end else begin
        skid_nxt   = word;
        skid_v_nxt = 1'b1;
      end
    end
  end

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = main_v_r;
  assign out_tdata  = main_r;

endmodule

>>> bench/tb_palette_pixel_expander_2bpp_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_palette_pixel_expander_2bpp_unit
// Self-checking bench for the 2bpp palette pixel expander.
// ----------------------------------------------------------------------------
// A short table of command items comes first. It covers the reset state, the
// byte extremes, every function, the spare function codes, a repeated begin of
// host mode and palette writes before and after host mode. A long random
// phase follows with render-heavy command mixes. A local predictor tracks the
// palette, the display mode and the host flags, and it computes each result.
// The monitor compares every accepted result field by field with the oldest
// pending prediction. Both stream sides stall in random bursts. The output
// side also holds off once for a long stretch, so that the input stalls.
// ----------------------------------------------------------------------------
module tb_palette_pixel_expander_2bpp_unit;

  // Spare function codes that must leave the state alone.
  localparam logic [ppe_pkg::FuncW-1:0] FUNC_SPARE6 = 3'd6;
  localparam logic [ppe_pkg::FuncW-1:0] FUNC_SPARE7 = 3'd7;

  // Fixed colours of the pale, dark and normal modes.
  localparam ppe_pkg::rgb_t CYAN_RGB   = 24'h00FFFF;
  localparam ppe_pkg::rgb_t DARK_RGB0  = 24'h0000FF;
  localparam ppe_pkg::rgb_t DARK_RGB1  = 24'h49658F;
  localparam ppe_pkg::rgb_t DARK_RGB2  = 24'h7891B5;
  localparam ppe_pkg::rgb_t NORM_RGB0  = 24'hD8D8D8;
  localparam ppe_pkg::rgb_t NORM_RGB1  = 24'hD00000;
  localparam ppe_pkg::rgb_t NORM_RGB2  = 24'h00A000;
  localparam ppe_pkg::rgb_t NORM_RGB3  = 24'h000000;

  localparam int unsigned PAL_DEPTH  = 16;
  localparam int unsigned RAND_ITEMS = 1825;
  localparam int unsigned CALM_ITEMS = 150;
  localparam int unsigned LONG_HOLD  = 80;
  localparam int unsigned HOLD_AT    = 500;
  localparam int unsigned BUSY_FROM  = 460;
  localparam int unsigned BUSY_TO    = 760;
  localparam int unsigned DRAIN_AT   = 1200;
  localparam int unsigned TAIL_WAIT  = 12;
  localparam int unsigned CYCLE_CAP  = 400000;

  // One result item, unpacked from out_tdata.
  typedef struct packed {
    ppe_pkg::rgb_t first;
    ppe_pkg::rgb_t second;
    ppe_pkg::rgb_t third;
    ppe_pkg::rgb_t fourth;
    logic [7:0]    read_data;
    logic          host_started;
    logic          pale_blue;
  } px_result_t;

  // One row of the directed command table.
  typedef struct {
    logic [ppe_pkg::FuncW-1:0] func;
    logic [7:0]                pix;
    logic [3:0]                idx;
    logic [7:0]                wval;
    bit                        typed;
    px_result_t                want;
  } cmd_row_t;

  logic                         clk;
  logic                         rst_n      = 1'b0;
  logic                         in_tvalid  = 1'b0;
  logic                         in_tready;
  logic [ppe_pkg::InDataW-1:0]  in_tdata   = '0;
  logic [ppe_pkg::FuncW-1:0]    in_tuser   = '0;
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [ppe_pkg::OutDataW-1:0] out_tdata;

  // Predictor state.
  logic [7:0]  pal_mem [PAL_DEPTH];
  logic [1:0]  disp_mode;
  logic        host_on;
  logic        pal_loaded;

  px_result_t  expected_pixels [$];
  cmd_row_t    cmd_table [$];
  int unsigned func_hits [8];
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned cycles;
  bit          calm;

  palette_pixel_expander_2bpp_unit #(
    .PALETTE_DEPTH (PAL_DEPTH)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Free-running clock with a 20 ns period.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Scale a channel of cmax steps to 8 bits, truncating.
  function automatic logic [7:0] widen_channel(input int unsigned c, input int unsigned cmax);
    int unsigned s;
    s = (c * 255) / cmax;
    return s[7:0];
  endfunction

  // Palette entries hold inverted RGB332.
  function automatic ppe_pkg::rgb_t entry_colour(input logic [7:0] val);
    logic [7:0] v;
    v = ~val;
    return {widen_channel(v[7:5], 7), widen_channel(v[4:2], 7), widen_channel(v[1:0], 3)};
  endfunction

  // Colour that one 2-bit pixel code maps to in the current display mode.
  function automatic ppe_pkg::rgb_t lane_colour(input logic [1:0] code);
    ppe_pkg::rgb_t c;
    if (disp_mode == ppe_pkg::MODE_PALE) begin
      c = CYAN_RGB;
    end else if (disp_mode == ppe_pkg::MODE_DARK) begin
      case (code)
        2'd0:    c = DARK_RGB0;
        2'd1:    c = DARK_RGB1;
        2'd2:    c = DARK_RGB2;
        default: c = CYAN_RGB;
      endcase
    end else if (pal_loaded) begin
      c = entry_colour(pal_mem[code]);
    end else begin
      case (code)
        2'd0:    c = NORM_RGB0;
        2'd1:    c = NORM_RGB1;
        2'd2:    c = NORM_RGB2;
        default: c = NORM_RGB3;
      endcase
    end
    return c;
  endfunction

  // Clear the predicted display state, as a reset or a display reset does.
  function automatic void clear_display();
    for (int i = 0; i < PAL_DEPTH; i++) pal_mem[i] = 8'h00;
    disp_mode  = ppe_pkg::MODE_PALE;
    host_on    = 1'b0;
    pal_loaded = 1'b0;
  endfunction

  // Apply one command item to the predicted state and return its result.
  function automatic px_result_t expand_command(input logic [ppe_pkg::FuncW-1:0] f,
                                                input logic [7:0] pix,
                                                input logic [3:0] idx,
                                                input logic [7:0] wval);
    px_result_t r;
    r = '0;
    case (f)
      ppe_pkg::FUNC_RENDER: begin
        r.first  = lane_colour(pix[7:6]);
        r.second = lane_colour(pix[5:4]);
        r.third  = lane_colour(pix[3:2]);
        r.fourth = lane_colour(pix[1:0]);
      end
      ppe_pkg::FUNC_PAL_WRITE: begin
        if (idx < PAL_DEPTH) pal_mem[idx] = wval;
        if (host_on) begin
          pal_loaded = 1'b1;
          disp_mode  = ppe_pkg::MODE_NORMAL;
        end
      end
      ppe_pkg::FUNC_PAL_READ: begin
        if (idx < PAL_DEPTH) r.read_data = pal_mem[idx];
      end
      ppe_pkg::FUNC_HOST_BEGIN: begin
        if (!host_on) begin
          host_on        = 1'b1;
          pal_loaded     = 1'b0;
          disp_mode      = ppe_pkg::MODE_NORMAL;
          r.host_started = 1'b1;
        end
      end
      ppe_pkg::FUNC_SET_DARK: disp_mode = ppe_pkg::MODE_DARK;
      ppe_pkg::FUNC_DISP_RESET: clear_display();
      default: ;
    endcase
    r.pale_blue = (disp_mode == ppe_pkg::MODE_PALE);
    return r;
  endfunction

  // Build a hand-written expectation.
  function automatic px_result_t typed_res(input ppe_pkg::rgb_t p0, input ppe_pkg::rgb_t p1,
                                           input ppe_pkg::rgb_t p2, input ppe_pkg::rgb_t p3,
                                           input logic [7:0] rd,
                                           input logic hs, input logic pb);
    px_result_t r;
    r.first        = p0;
    r.second       = p1;
    r.third        = p2;
    r.fourth       = p3;
    r.read_data    = rd;
    r.host_started = hs;
    r.pale_blue    = pb;
    return r;
  endfunction

  task automatic add_row(input logic [ppe_pkg::FuncW-1:0] f, input logic [7:0] pix,
                         input logic [3:0] idx, input logic [7:0] wval,
                         input bit typed, input px_result_t want);
    cmd_row_t row;
    row.func  = f;
    row.pix   = pix;
    row.idx   = idx;
    row.wval  = wval;
    row.typed = typed;
    row.want  = want;
    cmd_table.push_back(row);
  endtask

  // Render-heavy command mix for the random phase.
  function automatic logic [ppe_pkg::FuncW-1:0] pick_func();
    int unsigned roll;
    logic [ppe_pkg::FuncW-1:0] f;
    roll = $urandom_range(0, 99);
    if (roll < 45)      f = ppe_pkg::FUNC_RENDER;
    else if (roll < 65) f = ppe_pkg::FUNC_PAL_WRITE;
    else if (roll < 80) f = ppe_pkg::FUNC_PAL_READ;
    else if (roll < 87) f = ppe_pkg::FUNC_HOST_BEGIN;
    else if (roll < 92) f = ppe_pkg::FUNC_SET_DARK;
    else if (roll < 96) f = ppe_pkg::FUNC_DISP_RESET;
    else if (roll < 98) f = FUNC_SPARE6;
    else                f = FUNC_SPARE7;
    return f;
  endfunction

  // Present one item and hold it until the block takes it.
  task automatic offer_item(input logic [ppe_pkg::FuncW-1:0] f, input logic [7:0] pix,
                            input logic [3:0] idx, input logic [7:0] wval);
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {4'b0000, wval, idx, pix};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    func_hits[f]++;
    items_sent++;
  endtask

  // Random idle burst on the input side, skipped in the busy window and at the end.
  task automatic sender_gap();
    int unsigned n;
    if (!calm && !(items_sent >= BUSY_FROM && items_sent < BUSY_TO) &&
        $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 14);
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic cmp_field(input string tag, input logic [23:0] want, input logic [23:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, tag, want, got);
      mismatches++;
    end
  endtask

  // Result monitor.
  always @(posedge clk) begin
    px_result_t got;
    px_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.first        = out_tdata[23:0];
      got.second       = out_tdata[47:24];
      got.third        = out_tdata[71:48];
      got.fourth       = out_tdata[95:72];
      got.read_data    = out_tdata[103:96];
      got.host_started = out_tdata[104];
      got.pale_blue    = out_tdata[105];
      results_seen++;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result item, expected none, got %h", $time, out_tdata);
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        cmp_field("pixel_first", want.first, got.first);
        cmp_field("pixel_second", want.second, got.second);
        cmp_field("pixel_third", want.third, got.third);
        cmp_field("pixel_fourth", want.fourth, got.fourth);
        cmp_field("read_data", {16'h0, want.read_data}, {16'h0, got.read_data});
        cmp_field("host_mode_started", {23'h0, want.host_started}, {23'h0, got.host_started});
        cmp_field("is_pale_blue", {23'h0, want.pale_blue}, {23'h0, got.pale_blue});
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("timeout after %0d cycles with %0d results pending", cycles,
               expected_pixels.size());
      $display("tb_palette_pixel_expander_2bpp_unit: errors");
      $finish;
    end
  end

  // Output side: random stalls, one long hold-off, and none at the end.
  initial begin
    int unsigned n;
    bit          held;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && results_seen >= HOLD_AT) begin
        held = 1'b1;
        out_tready <= 1'b0;
        for (n = 0; n < LONG_HOLD; n++) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 14);
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        n = $urandom_range(1, 20);
        out_tready <= 1'b1;
        repeat (n) @(posedge clk);
      end
    end
  end

  // Stimulus.
  initial begin
    px_result_t                pred;
    cmd_row_t                  row;
    logic [ppe_pkg::FuncW-1:0] f;
    cycles       = 0;
    items_sent   = 0;
    results_seen = 0;
    mismatches   = 0;
    calm         = 1'b0;
    foreach (func_hits[i]) func_hits[i] = 0;
    clear_display();

    // Reset state, extremes, every function and the special cases.
    add_row(ppe_pkg::FUNC_RENDER, 8'h00, 4'd0, 8'h00, 1,
            typed_res(CYAN_RGB, CYAN_RGB, CYAN_RGB, CYAN_RGB, 8'h00, 0, 1));
    add_row(ppe_pkg::FUNC_RENDER, 8'hFF, 4'd15, 8'hFF, 1,
            typed_res(CYAN_RGB, CYAN_RGB, CYAN_RGB, CYAN_RGB, 8'h00, 0, 1));
    add_row(ppe_pkg::FUNC_PAL_READ, 8'h00, 4'd15, 8'h00, 1,
            typed_res(0, 0, 0, 0, 8'h00, 0, 1));
    // A palette write before host mode stores the value but keeps the mode.
    add_row(ppe_pkg::FUNC_PAL_WRITE, 8'h00, 4'd0, 8'hFF, 1,
            typed_res(0, 0, 0, 0, 8'h00, 0, 1));
    add_row(ppe_pkg::FUNC_PAL_READ, 8'h00, 4'd0, 8'h00, 1,
            typed_res(0, 0, 0, 0, 8'hFF, 0, 1));
    // Spare codes change nothing.
    add_row(FUNC_SPARE6, 8'hFF, 4'd15, 8'hFF, 1, typed_res(0, 0, 0, 0, 8'h00, 0, 1));
    add_row(FUNC_SPARE7, 8'hFF, 4'd15, 8'hFF, 1, typed_res(0, 0, 0, 0, 8'h00, 0, 1));
    add_row(ppe_pkg::FUNC_SET_DARK, 8'h00, 4'd0, 8'h00, 1,
            typed_res(0, 0, 0, 0, 8'h00, 0, 0));
    add_row(ppe_pkg::FUNC_RENDER, 8'h1B, 4'd0, 8'h00, 1,
            typed_res(DARK_RGB0, DARK_RGB1, DARK_RGB2, CYAN_RGB, 8'h00, 0, 0));
    add_row(ppe_pkg::FUNC_RENDER, 8'hE4, 4'd0, 8'h00, 0, '0);
    add_row(ppe_pkg::FUNC_HOST_BEGIN, 8'h00, 4'd0, 8'h00, 1,
            typed_res(0, 0, 0, 0, 8'h00, 1, 0));
    // A second begin while host mode is on has no effect.
    add_row(ppe_pkg::FUNC_HOST_BEGIN, 8'h00, 4'd0, 8'h00, 1,
            typed_res(0, 0, 0, 0, 8'h00, 0, 0));
    add_row(ppe_pkg::FUNC_RENDER, 8'h1B, 4'd0, 8'h00, 1,
            typed_res(NORM_RGB0, NORM_RGB1, NORM_RGB2, NORM_RGB3, 8'h00, 0, 0));
    // Palette writes in host mode switch rendering to the palette entries.
    add_row(ppe_pkg::FUNC_PAL_WRITE, 8'h00, 4'd1, 8'h00, 0, '0);
    add_row(ppe_pkg::FUNC_PAL_WRITE, 8'h00, 4'd2, 8'h6D, 0, '0);
    add_row(ppe_pkg::FUNC_PAL_WRITE, 8'h00, 4'd3, 8'h92, 0, '0);
    add_row(ppe_pkg::FUNC_PAL_WRITE, 8'h00, 4'd15, 8'hA5, 0, '0);
    add_row(ppe_pkg::FUNC_RENDER, 8'h1B, 4'd0, 8'h00, 0, '0);
    add_row(ppe_pkg::FUNC_RENDER, 8'hE4, 4'd0, 8'h00, 0, '0);
    add_row(ppe_pkg::FUNC_PAL_READ, 8'h00, 4'd15, 8'h00, 0, '0);
    add_row(ppe_pkg::FUNC_SET_DARK, 8'h00, 4'd0, 8'h00, 1,
            typed_res(0, 0, 0, 0, 8'h00, 0, 0));
    add_row(ppe_pkg::FUNC_RENDER, 8'hFF, 4'd0, 8'h00, 1,
            typed_res(CYAN_RGB, CYAN_RGB, CYAN_RGB, CYAN_RGB, 8'h00, 0, 0));
    // In host mode a palette write leaves dark mode again.
    add_row(ppe_pkg::FUNC_PAL_WRITE, 8'h00, 4'd5, 8'h3C, 0, '0);
    add_row(ppe_pkg::FUNC_RENDER, 8'h1B, 4'd0, 8'h00, 0, '0);
    add_row(ppe_pkg::FUNC_DISP_RESET, 8'h00, 4'd0, 8'h00, 1,
            typed_res(0, 0, 0, 0, 8'h00, 0, 1));
    add_row(ppe_pkg::FUNC_PAL_READ, 8'h00, 4'd0, 8'h00, 1,
            typed_res(0, 0, 0, 0, 8'h00, 0, 1));
    add_row(ppe_pkg::FUNC_RENDER, 8'h55, 4'd0, 8'h00, 1,
            typed_res(CYAN_RGB, CYAN_RGB, CYAN_RGB, CYAN_RGB, 8'h00, 0, 1));

    // Hold synchronous reset, then release it.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    foreach (cmd_table[i]) begin
      row = cmd_table[i];
      offer_item(row.func, row.pix, row.idx, row.wval);
      pred = expand_command(row.func, row.pix, row.idx, row.wval);
      expected_pixels.push_back(row.typed ? row.want : pred);
      sender_gap();
    end
    wait_drained();

    // Random phase.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == DRAIN_AT) wait_drained();
      if (n >= RAND_ITEMS - CALM_ITEMS) calm = 1'b1;
      f = pick_func();
      offer_item(f, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                 8'($urandom_range(0, 255)));
      pred = expand_command(in_tuser, in_tdata[7:0], in_tdata[11:8], in_tdata[19:12]);
      expected_pixels.push_back(pred);
      sender_gap();
    end

    // Drain, then give the block a few more cycles to misbehave.
    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk);

    $display("ran %0d items: %0d renders, %0d palette writes, %0d reads, %0d host begins",
             items_sent, func_hits[ppe_pkg::FUNC_RENDER], func_hits[ppe_pkg::FUNC_PAL_WRITE],
             func_hits[ppe_pkg::FUNC_PAL_READ], func_hits[ppe_pkg::FUNC_HOST_BEGIN]);
    $display("  %0d dark sets, %0d display resets, %0d spare codes; %0d results, %0d mismatches",
             func_hits[ppe_pkg::FUNC_SET_DARK], func_hits[ppe_pkg::FUNC_DISP_RESET],
             func_hits[FUNC_SPARE6] + func_hits[FUNC_SPARE7], results_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb_palette_pixel_expander_2bpp_unit: clean");
    end else begin
      $display("tb_palette_pixel_expander_2bpp_unit: errors");
    end
    $finish;
  end

endmodule
